>>> hdl/ows_pkg.sv
// Package for the one-wire temperature sequencer.
// Holds the step codes, phase codes, bus commands, register indexes and the
// config and result structs used by the core and the top level.
package ows_pkg;

    // Sequencer steps of one measurement cycle
    typedef enum logic [3:0] {
        SEQ_IDLE    = 4'd0,
        SEQ_RST1    = 4'd1,
        SEQ_SKIP1   = 4'd2,
        SEQ_CONV    = 4'd3,
        SEQ_WAIT    = 4'd4,
        SEQ_RST2    = 4'd5,
        SEQ_SKIP2   = 4'd6,
        SEQ_RDCMD   = 4'd7,
        SEQ_READ_LO = 4'd8,
        SEQ_READ_HI = 4'd9
    } seq_step_t;

    // Phase codes reported with each result
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_RESET = 3'd1;
    localparam logic [2:0] PH_WRITE = 3'd2;
    localparam logic [2:0] PH_CONV  = 3'd3;
    localparam logic [2:0] PH_READ  = 3'd4;

    // Slot sub-states
    localparam logic [2:0] SLOT_LOW  = 3'd0;
    localparam logic [2:0] SLOT_HIGH = 3'd1;
    localparam logic [2:0] SLOT_TAIL = 3'd2;

    // Bus commands
    localparam logic [7:0] CMD_SKIP    = 8'hcc;
    localparam logic [7:0] CMD_CONVERT = 8'h44;
    localparam logic [7:0] CMD_READ    = 8'hbe;

    // Short part of a slot in microseconds
    localparam logic [9:0] SHORT_US = 10'd2;

    // Register indexes
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_CONV_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_LOW = 3'd2;
    localparam logic [2:0] REG_SLOT_LONG = 3'd3;
    localparam logic [2:0] REG_RD_SAMPLE = 3'd4;
    localparam logic [2:0] REG_RD_RECOV  = 3'd5;

    typedef struct packed {
        logic        enable;
        logic [11:0] conv_wait_ms;
        logic [9:0]  reset_low_us;
        logic [9:0]  slot_long_us;
        logic [5:0]  read_sample_us;
        logic [9:0]  read_recovery_us;
    } cfg_t;

    typedef struct packed {
        logic               drive_low;
        logic               temp_valid;
        logic signed [15:0] temperature;
        logic [2:0]         phase;
    } res_t;

    // Step that follows a reset or write step
    function automatic seq_step_t next_step(input seq_step_t s);
        seq_step_t n;
        case (s)
            SEQ_RST1:  n = SEQ_SKIP1;
            SEQ_SKIP1: n = SEQ_CONV;
            SEQ_CONV:  n = SEQ_WAIT;
            SEQ_RST2:  n = SEQ_SKIP2;
            SEQ_SKIP2: n = SEQ_RDCMD;
            SEQ_RDCMD: n = SEQ_READ_LO;
            default:   n = SEQ_IDLE;
        endcase
        return n;
    endfunction

endpackage

>>> hdl/ows_core.sv
// Sequencer core: step state, slot timing and the read shifter.
// One request advances the state by one microsecond. Depends on ows_pkg.
module ows_core #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic          line_in,
    input  logic          ms_tick,
    input  ows_pkg::cfg_t cfg,
    output ows_pkg::res_t res
);

    localparam int LW = ((COUNT_WIDTH > 10) ? COUNT_WIDTH : 10) + 1;

    ows_pkg::seq_step_t     step_reg, step_next;
    logic [2:0]             slot_reg, slot_next;
    logic [COUNT_WIDTH-1:0] us_reg, us_next;
    logic [11:0]            ms_reg, ms_next;
    logic [2:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic [7:0]             low_reg, low_next;
    logic [15:0]            temp_reg, temp_next;

    // Last microsecond of a timed part: length reached or counter saturated
    function automatic logic timed_done(input logic [COUNT_WIDTH-1:0] cnt,
                                        input logic [9:0] len);
        logic [LW-1:0] c1;
        logic [LW-1:0] l1;
        c1 = LW'(cnt) + LW'(1);
        l1 = (len == 10'd0) ? LW'(1) : LW'(len);
        return (c1 >= l1) || (&cnt);
    endfunction

    logic               enter_en;
    ows_pkg::seq_step_t enter_step;
    logic               tdone;
    logic               cur_bit;
    logic [7:0]         shifted;
    logic [7:0]         rd_byte;

    // Next state for one microsecond
    always_comb begin
        step_next  = step_reg;
        slot_next  = slot_reg;
        us_next    = us_reg;
        ms_next    = ms_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        low_next   = low_reg;
        temp_next  = temp_reg;
        enter_en   = 1'b0;
        enter_step = ows_pkg::SEQ_IDLE;
        tdone      = 1'b0;
        cur_bit    = shift_reg[bit_reg];
        shifted    = {line_in, shift_reg[7:1]};
        rd_byte    = (us_reg == '0) ? shifted : shift_reg;

        case (step_reg)
            ows_pkg::SEQ_RST1, ows_pkg::SEQ_RST2: begin
                if (slot_reg == ows_pkg::SLOT_LOW) begin
                    tdone   = timed_done(us_reg, cfg.reset_low_us);
                    us_next = tdone ? '0 : us_reg + 1'b1;
                    if (tdone) slot_next = ows_pkg::SLOT_HIGH;
                end else if (slot_reg == ows_pkg::SLOT_HIGH) begin
                    // wait for the presence pulse to start
                    if (!line_in) slot_next = ows_pkg::SLOT_TAIL;
                end else if (line_in) begin
                    enter_en   = 1'b1;
                    enter_step = ows_pkg::next_step(step_reg);
                end
            end
            ows_pkg::SEQ_SKIP1, ows_pkg::SEQ_CONV,
            ows_pkg::SEQ_SKIP2, ows_pkg::SEQ_RDCMD: begin
                if (slot_reg == ows_pkg::SLOT_LOW) begin
                    tdone   = timed_done(us_reg,
                                         cur_bit ? ows_pkg::SHORT_US : cfg.slot_long_us);
                    us_next = tdone ? '0 : us_reg + 1'b1;
                    if (tdone) slot_next = ows_pkg::SLOT_HIGH;
                end else begin
                    tdone   = timed_done(us_reg,
                                         cur_bit ? cfg.slot_long_us : ows_pkg::SHORT_US);
                    us_next = tdone ? '0 : us_reg + 1'b1;
                    if (tdone) begin
                        slot_next = ows_pkg::SLOT_LOW;
                        bit_next  = bit_reg + 3'd1;
                        if (bit_reg == 3'd7) begin
                            enter_en   = 1'b1;
                            enter_step = ows_pkg::next_step(step_reg);
                        end
                    end
                end
            end
            ows_pkg::SEQ_WAIT: begin
                if (ms_tick) begin
                    if (ms_reg >= cfg.conv_wait_ms) begin
                        enter_en   = 1'b1;
                        enter_step = ows_pkg::SEQ_RST2;
                    end else begin
                        ms_next = ms_reg + 12'd1;
                    end
                end
            end
            ows_pkg::SEQ_READ_LO, ows_pkg::SEQ_READ_HI: begin
                if (slot_reg == ows_pkg::SLOT_LOW) begin
                    tdone   = timed_done(us_reg, ows_pkg::SHORT_US);
                    us_next = tdone ? '0 : us_reg + 1'b1;
                    if (tdone) slot_next = ows_pkg::SLOT_HIGH;
                end else if (slot_reg == ows_pkg::SLOT_HIGH) begin
                    tdone   = timed_done(us_reg, {4'd0, cfg.read_sample_us});
                    us_next = tdone ? '0 : us_reg + 1'b1;
                    if (tdone) slot_next = ows_pkg::SLOT_TAIL;
                end else begin
                    // sample on the first recovery microsecond
                    shift_next = rd_byte;
                    tdone   = timed_done(us_reg, cfg.read_recovery_us);
                    us_next = tdone ? '0 : us_reg + 1'b1;
                    if (tdone) begin
                        slot_next = ows_pkg::SLOT_LOW;
                        bit_next  = bit_reg + 3'd1;
                        if (bit_reg == 3'd7) begin
                            enter_en = 1'b1;
                            if (step_reg == ows_pkg::SEQ_READ_LO) begin
                                low_next   = rd_byte;
                                enter_step = ows_pkg::SEQ_READ_HI;
                            end else begin
                                temp_next  = {rd_byte, low_reg};
                                enter_step = ows_pkg::SEQ_IDLE;
                            end
                        end
                    end
                end
            end
            default: begin
                step_next = ows_pkg::SEQ_IDLE;
                if (cfg.enable) begin
                    enter_en   = 1'b1;
                    enter_step = ows_pkg::SEQ_RST1;
                end
            end
        endcase

        // Enter a step: clear slot timing, load the command or a zero read byte
        if (enter_en) begin
            step_next = enter_step;
            slot_next = ows_pkg::SLOT_LOW;
            us_next   = '0;
            bit_next  = 3'd0;
            case (enter_step)
                ows_pkg::SEQ_SKIP1, ows_pkg::SEQ_SKIP2: shift_next = ows_pkg::CMD_SKIP;
                ows_pkg::SEQ_CONV:                      shift_next = ows_pkg::CMD_CONVERT;
                ows_pkg::SEQ_RDCMD:                     shift_next = ows_pkg::CMD_READ;
                ows_pkg::SEQ_READ_LO, ows_pkg::SEQ_READ_HI: shift_next = 8'd0;
                default: ;
            endcase
            if (enter_step == ows_pkg::SEQ_WAIT) ms_next = 12'd0;
        end
    end

    // Result of this microsecond: drive, phase, temperature, new-reading flag
    always_comb begin
        res.drive_low   = 1'b0;
        res.temp_valid  = 1'b0;
        res.phase       = ows_pkg::PH_IDLE;
        res.temperature = temp_next;
        case (step_reg)
            ows_pkg::SEQ_RST1, ows_pkg::SEQ_RST2: begin
                res.phase     = ows_pkg::PH_RESET;
                res.drive_low = (slot_reg == ows_pkg::SLOT_LOW);
            end
            ows_pkg::SEQ_SKIP1, ows_pkg::SEQ_CONV,
            ows_pkg::SEQ_SKIP2, ows_pkg::SEQ_RDCMD: begin
                res.phase     = ows_pkg::PH_WRITE;
                res.drive_low = (slot_reg == ows_pkg::SLOT_LOW);
            end
            ows_pkg::SEQ_WAIT: begin
                res.phase = ows_pkg::PH_CONV;
            end
            ows_pkg::SEQ_READ_LO, ows_pkg::SEQ_READ_HI: begin
                res.phase      = ows_pkg::PH_READ;
                res.drive_low  = (slot_reg == ows_pkg::SLOT_LOW);
                // last recovery microsecond of the last bit of the high byte
                res.temp_valid = (step_reg == ows_pkg::SEQ_READ_HI) &&
                                 (slot_reg == ows_pkg::SLOT_TAIL) && (bit_reg == 3'd7) &&
                                 timed_done(us_reg, cfg.read_recovery_us);
            end
            default: ;
        endcase
    end

    // Advance state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ows_pkg::SEQ_IDLE;
            slot_reg  <= ows_pkg::SLOT_LOW;
            us_reg    <= '0;
            ms_reg    <= 12'd0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
            low_reg   <= 8'd0;
            temp_reg  <= 16'd0;
        end else if (step_en) begin
            step_reg  <= step_next;
            slot_reg  <= slot_next;
            us_reg    <= us_next;
            ms_reg    <= ms_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            low_reg   <= low_next;
            temp_reg  <= temp_next;
        end
    end

endmodule

>>> hdl/one_wire_temperature_sequencer_unit.sv
// Top level of the one-wire temperature sequencer: APB registers, request
// handshake and result register. Depends on ows_pkg and ows_core.
//
// Each input request is one microsecond of bus time (sampled line level and a
// millisecond flag) and yields exactly one result (drive level, new-reading
// flag, last temperature, phase). One request is taken every clock cycle unless
// the result stalls; the result appears in the cycle after acceptance from a
// single output register, and the next request is taken in the same cycle as
// the result leaves. The core's state registers are updated once per request.
// Registers sit at byte addresses 0x00 enable, 0x04 conv_wait_ms,
// 0x08 reset_low_us, 0x0c slot_long_us, 0x10 read_sample_us,
// 0x14 read_recovery_us; change them only while the block is idle.
module one_wire_temperature_sequencer_unit #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_line_in,
    input  logic               s_ms_tick,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_drive_low,
    output logic               m_temp_valid,
    output logic signed [15:0] m_temperature,
    output logic [2:0]         m_phase
);

    ows_pkg::cfg_t cfg;
    ows_pkg::res_t core_res;
    ows_pkg::res_t res_reg;
    logic          m_valid_reg, m_valid_next;
    logic          accept;
    logic          cfg_wr;
    logic [2:0]    reg_idx;

    logic        enable_reg;
    logic [11:0] conv_wait_reg;
    logic [9:0]  reset_low_reg;
    logic [9:0]  slot_long_reg;
    logic [5:0]  rd_sample_reg;
    logic [9:0]  rd_recov_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            conv_wait_reg <= 12'd1000;
            reset_low_reg <= 10'd600;
            slot_long_reg <= 10'd80;
            rd_sample_reg <= 6'd5;
            rd_recov_reg  <= 10'd500;
        end else if (cfg_wr) begin
            case (reg_idx)
                ows_pkg::REG_ENABLE:    enable_reg    <= pwdata[0];
                ows_pkg::REG_CONV_WAIT: conv_wait_reg <= pwdata[11:0];
                ows_pkg::REG_RESET_LOW: reset_low_reg <= pwdata[9:0];
                ows_pkg::REG_SLOT_LONG: slot_long_reg <= pwdata[9:0];
                ows_pkg::REG_RD_SAMPLE: rd_sample_reg <= pwdata[5:0];
                ows_pkg::REG_RD_RECOV:  rd_recov_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (reg_idx)
            ows_pkg::REG_ENABLE:    prdata = {31'd0, enable_reg};
            ows_pkg::REG_CONV_WAIT: prdata = {20'd0, conv_wait_reg};
            ows_pkg::REG_RESET_LOW: prdata = {22'd0, reset_low_reg};
            ows_pkg::REG_SLOT_LONG: prdata = {22'd0, slot_long_reg};
            ows_pkg::REG_RD_SAMPLE: prdata = {26'd0, rd_sample_reg};
            ows_pkg::REG_RD_RECOV:  prdata = {22'd0, rd_recov_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.enable           = enable_reg;
        cfg.conv_wait_ms     = conv_wait_reg;
        cfg.reset_low_us     = reset_low_reg;
        cfg.slot_long_us     = slot_long_reg;
        cfg.read_sample_us   = rd_sample_reg;
        cfg.read_recovery_us = rd_recov_reg;
    end

    // Take a request whenever the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    ows_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .line_in (s_line_in),
        .ms_tick (s_ms_tick),
        .cfg     (cfg),
        .res     (core_res)
    );

    // Hold the result until taken
    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= core_res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_low   = res_reg.drive_low;
    assign m_temp_valid  = res_reg.temp_valid;
    assign m_temperature = res_reg.temperature;
    assign m_phase       = res_reg.phase;

endmodule

>>> hdl/ows_checker.sv
// Port-level checks for the one-wire temperature sequencer, bound to the top.
// Depends on ows_pkg for the phase codes.
module ows_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_drive_low,
    input logic               m_temp_valid,
    input logic signed [15:0] m_temperature,
    input logic [2:0]         m_phase
);

    // A new reading only comes out of the read phase
    a_valid_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_temp_valid) |-> (m_phase == ows_pkg::PH_READ))
        else $error("temp_valid outside read phase");

    // The bus is never pulled low while idle or waiting for conversion
    a_drive_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_low) |->
            (m_phase == ows_pkg::PH_RESET || m_phase == ows_pkg::PH_WRITE ||
             m_phase == ows_pkg::PH_READ))
        else $error("drive_low in a phase that never drives");

    // Temperature changes between back-to-back results only with a new reading
    a_temp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((m_valid && m_ready) ##1 (m_valid && m_ready && !m_temp_valid)) |->
            $stable(m_temperature))
        else $error("temperature changed without temp_valid");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_temperature) && $stable(m_phase) &&
             $stable(m_drive_low) && $stable(m_temp_valid)))
        else $error("stalled result changed");

    // Every accepted request shows a result on the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted request produced no result");

endmodule

bind one_wire_temperature_sequencer_unit ows_checker u_ows_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_drive_low   (m_drive_low),
    .m_temp_valid  (m_temp_valid),
    .m_temperature (m_temperature),
    .m_phase       (m_phase)
);
